@@ src/utf8sd_pkg.sv @@
// shared types and constants for the utf8 stream decoder
package utf8sd_pkg;

  localparam int CP_W     = 21;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

  typedef struct packed {
    logic [1:0]      replays;
    logic            has_final;
    logic [CP_W-1:0] final_cp;
    logic            final_eot;
  } job_t;

endpackage

@@ src/utf8_stream_decoder.sv @@
// top level of the utf8 stream decoder
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  in_byte
//   output   out        out_valid / out_stall code_point, end_of_text, last
//
// one byte accepted per cycle while the job queue has room
// each byte yields zero to four result requests, one per cycle from the output register while out_stall is low
// a broken sequence replays one request per byte already taken, in one queue job; input stalls only on a full queue
// synchronous active-high reset clears sequence state, queue and output valid
// output stall holds the output register; the queue absorbs two more jobs before input stalls
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] code_point,
  output logic        end_of_text,
  output logic        last
);

  utf8sd_pkg::job_t push_job;
  utf8sd_pkg::job_t head_job;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;

  utf8sd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  utf8sd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head_job (head_job)
  );

  utf8sd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (q_empty),
    .head_job    (head_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_point  (code_point),
    .end_of_text (end_of_text),
    .last        (last)
  );

endmodule

@@ src/utf8sd_front.sv @@
// front end: accepts text bytes, tracks the pending sequence, builds result jobs
module utf8sd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte,
  input  logic              q_full,
  output logic              push,
  output utf8sd_pkg::job_t  push_job
);

  logic [utf8sd_pkg::CP_W-1:0] partial_code, partial_code_next;
  logic [1:0]                  bytes_remaining, bytes_remaining_next;
  logic [1:0]                  bytes_taken, bytes_taken_next;
  logic                        accept;
  logic                        cont;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign cont     = (in_byte[7:6] == 2'b10);

  always_comb begin
    partial_code_next    = partial_code;
    bytes_remaining_next = bytes_remaining;
    bytes_taken_next     = bytes_taken;
    push_job.replays     = 2'd0;
    push_job.has_final   = 1'b0;
    push_job.final_cp    = '0;
    push_job.final_eot   = 1'b0;
    if (bytes_remaining != 2'd0 && cont) begin
      partial_code_next    = {partial_code[utf8sd_pkg::CP_W-7:0], in_byte[5:0]};
      bytes_taken_next     = bytes_taken + 2'd1;
      bytes_remaining_next = bytes_remaining - 2'd1;
      if (bytes_remaining == 2'd1) begin
        push_job.has_final   = 1'b1;
        push_job.final_cp    = partial_code_next;
        partial_code_next    = '0;
        bytes_taken_next     = 2'd0;
      end
    end else begin
      if (bytes_remaining != 2'd0) begin
        push_job.replays = bytes_taken + 2'd1;
      end
      partial_code_next    = '0;
      bytes_remaining_next = 2'd0;
      bytes_taken_next     = 2'd0;
      if (in_byte == 8'h00) begin
        push_job.has_final = 1'b1;
        push_job.final_eot = 1'b1;
      end else if (in_byte[7] == 1'b0) begin
        push_job.has_final = 1'b1;
        push_job.final_cp  = {{(utf8sd_pkg::CP_W-8){1'b0}}, in_byte};
      end else if (in_byte[7:5] == 3'b110) begin
        partial_code_next    = {{(utf8sd_pkg::CP_W-5){1'b0}}, in_byte[4:0]};
        bytes_remaining_next = 2'd1;
      end else if (in_byte[7:4] == 4'b1110) begin
        partial_code_next    = {{(utf8sd_pkg::CP_W-4){1'b0}}, in_byte[3:0]};
        bytes_remaining_next = 2'd2;
      end else if (in_byte[7:3] == 5'b11110) begin
        partial_code_next    = {{(utf8sd_pkg::CP_W-3){1'b0}}, in_byte[2:0]};
        bytes_remaining_next = 2'd3;
      end else begin
        push_job.has_final = 1'b1;
        push_job.final_cp  = utf8sd_pkg::REPLACEMENT;
      end
    end
  end

  assign push = accept && (push_job.has_final || (push_job.replays != 2'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_code    <= '0;
      bytes_remaining <= 2'd0;
      bytes_taken     <= 2'd0;
    end else if (accept) begin
      partial_code    <= partial_code_next;
      bytes_remaining <= bytes_remaining_next;
      bytes_taken     <= bytes_taken_next;
    end
  end

endmodule

@@ src/utf8sd_queue.sv @@
// short job queue between front and back
module utf8sd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  utf8sd_pkg::job_t  push_job,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output utf8sd_pkg::job_t  head_job
);

  utf8sd_pkg::job_t                 slots [utf8sd_pkg::QDEPTH];
  logic [utf8sd_pkg::QPTR_W-1:0]    wr_ptr;
  logic [utf8sd_pkg::QPTR_W-1:0]    rd_ptr;
  logic [utf8sd_pkg::QCNT_W-1:0]    count;

  assign full     = (count == utf8sd_pkg::QCNT_W'(utf8sd_pkg::QDEPTH));
  assign empty    = (count == '0);
  assign head_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/utf8sd_back.sv @@
// back end: expands queued jobs into result requests through an output register
module utf8sd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        empty,
  input  utf8sd_pkg::job_t            head_job,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [utf8sd_pkg::CP_W-1:0] code_point,
  output logic                        end_of_text,
  output logic                        last
);

  logic [1:0]                  emitted;
  logic                        load;
  logic                        gen_last;
  logic [utf8sd_pkg::CP_W-1:0] gen_cp;
  logic                        gen_eot;

  assign load = !empty && (!out_valid || !out_stall);

  always_comb begin
    if (emitted < head_job.replays) begin
      gen_cp   = utf8sd_pkg::REPLACEMENT;
      gen_eot  = 1'b0;
      gen_last = (emitted == head_job.replays - 2'd1) && !head_job.has_final;
    end else begin
      gen_cp   = head_job.final_cp;
      gen_eot  = head_job.final_eot;
      gen_last = 1'b1;
    end
  end

  assign pop = load && gen_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      emitted   <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        emitted   <= gen_last ? 2'd0 : emitted + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_point  <= gen_cp;
      end_of_text <= gen_eot;
      last        <= gen_last;
    end
  end

endmodule
